@@ design/button_click_classifier_top_macros.svh @@
// Assertion macros shared by the button click classifier modules.
// Depends on nothing; every user has a clock named clk and a reset named rst.
`ifndef BUTTON_CLICK_CLASSIFIER_TOP_MACROS_SVH
`define BUTTON_CLICK_CLASSIFIER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BCC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/bcc_pkg.sv @@
// Shared types and constants of the button click classifier.
// Depends on nothing; used by bcc_lane, bcc_merge and the top level.
`default_nettype none

package bcc_pkg;

  localparam int BUTTONS = 8;
  localparam int HOLD_W  = 15;
  localparam logic [HOLD_W-1:0] HOLD_MAX = 15'h7FFF;

  typedef enum logic [2:0] {
    KIND_PRESSED  = 3'd0,
    KIND_RELEASED = 3'd1,
    KIND_CLICK    = 3'd2,
    KIND_DOUBLE   = 3'd3,
    KIND_LONG     = 3'd4
  } bcc_kind_t;

  typedef enum logic [2:0] {
    REG_BUTTON_COUNT  = 3'd0,
    REG_ACTIVE_LEVELS = 3'd1,
    REG_DEBOUNCED     = 3'd2,
    REG_CLICK_TIME    = 3'd3,
    REG_LONG_TIME     = 3'd4,
    REG_DOUBLE_WINDOW = 3'd5
  } bcc_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LANES,
    ST_DRAIN
  } bcc_state_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [7:0]  raw_levels;
  } bcc_in_t;

  typedef struct packed {
    logic [2:0] event_kind;
    logic [2:0] button_index;
    logic       last_event;
  } bcc_out_t;

  typedef struct packed {
    logic              debounced;
    logic [HOLD_W-1:0] click_min;
    logic [HOLD_W-1:0] long_time;
    logic [HOLD_W-1:0] window;
  } bcc_cfg_t;

  typedef struct packed {
    logic              en;
    logic              dt_nz;
    logic [HOLD_W-1:0] dt;
  } bcc_step_t;

  typedef struct packed {
    logic      valid;
    bcc_kind_t kind;
  } bcc_lane_ev_t;

endpackage

`default_nettype wire

@@ design/bcc_lane.sv @@
// One button slot: hold/window timekeeping and release classification.
// Depends on bcc_pkg.
`default_nettype none

module bcc_lane (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire bcc_pkg::bcc_step_t   step,
  input  wire bcc_pkg::bcc_cfg_t    cfg,
  input  wire logic                 pressed_now,
  output bcc_pkg::bcc_lane_ev_t     ev
);

  logic                       pflag, pflag_next;
  logic                       pend, pend_next;
  logic [bcc_pkg::HOLD_W-1:0] hold, hold_next;

  logic                       pend_u;
  logic [bcc_pkg::HOLD_W-1:0] hold_u;
  logic [bcc_pkg::HOLD_W:0]   sum;
  bcc_pkg::bcc_kind_t         rel_kind;

  // Advance elapsed time, then classify the current level.
  always_comb begin
    sum    = {1'b0, hold} + {1'b0, step.dt};
    pend_u = pend;
    hold_u = hold;
    if (step.dt_nz) begin
      if (pflag) begin
        hold_u = (sum >= {1'b0, bcc_pkg::HOLD_MAX}) ? bcc_pkg::HOLD_MAX
                                                    : sum[bcc_pkg::HOLD_W-1:0];
      end else if (pend) begin
        if (step.dt >= hold) begin
          pend_u = 1'b0;
          hold_u = '0;
        end else begin
          hold_u = hold - step.dt;
        end
      end
    end

    priority if (hold_u >= cfg.long_time) begin
      rel_kind = bcc_pkg::KIND_LONG;
    end else if (hold_u >= cfg.click_min) begin
      rel_kind = pend_u ? bcc_pkg::KIND_DOUBLE : bcc_pkg::KIND_CLICK;
    end else begin
      rel_kind = bcc_pkg::KIND_RELEASED;
    end

    pflag_next = pflag;
    pend_next  = pend_u;
    hold_next  = hold_u;
    ev.valid   = 1'b0;
    ev.kind    = bcc_pkg::KIND_PRESSED;
    if (pressed_now) begin
      if (!pflag) begin
        ev.valid   = !cfg.debounced;
        pflag_next = 1'b1;
        hold_next  = '0;
      end
    end else if (pflag) begin
      ev.valid   = (rel_kind != bcc_pkg::KIND_RELEASED) || !cfg.debounced;
      ev.kind    = rel_kind;
      pflag_next = 1'b0;
      pend_next  = 1'b1;
      hold_next  = cfg.window;
    end
    ev.valid = ev.valid && step.en;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pflag <= 1'b0;
      pend  <= 1'b0;
      hold  <= '0;
    end else if (step.en) begin
      pflag <= pflag_next;
      pend  <= pend_next;
      hold  <= hold_next;
    end
  end

endmodule

`default_nettype wire

@@ design/bcc_merge.sv @@
// Merge stage: latch lane events, drain them in slot order into the output register.
// Depends on bcc_pkg and the assertion macro header.
`default_nettype none
`include "button_click_classifier_top_macros.svh"

module bcc_merge (
  input  wire logic                                           clk,
  input  wire logic                                           rst,
  input  wire logic                                           load,
  input  wire bcc_pkg::bcc_lane_ev_t [bcc_pkg::BUTTONS-1:0]   lane_ev,
  output logic                                                empty,
  output logic                                                out_valid,
  input  wire logic                                           out_stall,
  output bcc_pkg::bcc_out_t                                   out_item
);

  logic [bcc_pkg::BUTTONS-1:0] mask;
  logic [bcc_pkg::BUTTONS-1:0] rest;
  bcc_pkg::bcc_kind_t          kinds [bcc_pkg::BUTTONS];
  logic [2:0]                  pick;
  logic                        load_out;

  // Lowest pending slot goes first.
  always_comb begin
    pick = '0;
    for (int i = bcc_pkg::BUTTONS - 1; i >= 0; i--) begin
      if (mask[i]) begin
        pick = 3'(i);
      end
    end
  end

  assign rest     = mask & (mask - 1'b1);
  assign empty    = (mask == '0);
  assign load_out = !empty && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      mask      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        for (int i = 0; i < bcc_pkg::BUTTONS; i++) begin
          mask[i] <= lane_ev[i].valid;
        end
      end else if (load_out) begin
        mask <= rest;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < bcc_pkg::BUTTONS; i++) begin
        kinds[i] <= lane_ev[i].kind;
      end
    end
    if (load_out) begin
      out_item.event_kind   <= kinds[pick];
      out_item.button_index <= pick;
      out_item.last_event   <= (rest == '0);
    end
  end

  `BCC_ASSERT_SAME(a_load_when_drained, load, empty, "lane events loaded over undrained events")
  `BCC_ASSERT_NEXT(a_last_clears, load_out && (rest == '0), empty && out_item.last_event,
                   "last event sent but events remain")

endmodule

`default_nettype wire

@@ design/button_click_classifier_top.sv @@
// Button click classifier: top level with config registers, sequencer and lane array.
// Depends on bcc_pkg, bcc_lane, bcc_merge and the assertion macro header.
//
// Usage:
//  - Input channel (in_valid / in_stall / in_item): one item per button edge event,
//    a millisecond timestamp and the raw level of each of the eight slots.
//  - Output channel (out_valid / out_stall / out_item): zero to eight result items per
//    input item, slots in ascending order; last_event marks the final one.
//  - Config port (cfg_write / cfg_index / cfg_data): write while the block is idle.
//  - Timing: an accepted item passes through the lane step, where all slots in use update
//    in parallel, then drains one result per cycle through the merge stage while the
//    receiver does not stall. The first result goes through the step registers, the
//    merge mask and the output register. The block stays busy until the merge stage
//    holds no more events; the next item can be taken while a stalled last result
//    still sits in the output register.
//  - A button count of zero drops the item at once with no state change.
//  - Reset clears all slot state and the previous timestamp, and loads register defaults.
//  - A stalled receiver holds the output register; draining halts until it frees.
`default_nettype none
`include "button_click_classifier_top_macros.svh"

module button_click_classifier_top (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire bcc_pkg::bcc_in_t     in_item,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output bcc_pkg::bcc_out_t         out_item,
  input  wire logic                 cfg_write,
  input  wire logic [2:0]           cfg_index,
  input  wire logic [14:0]          cfg_data
);

  // Configuration registers.
  logic [3:0]        button_count;
  logic [7:0]        active_levels;
  bcc_pkg::bcc_cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      button_count   <= '0;
      active_levels  <= '0;
      cfg.debounced  <= 1'b0;
      cfg.click_min  <= 15'd50;
      cfg.long_time  <= 15'd1000;
      cfg.window     <= 15'd500;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bcc_pkg::REG_BUTTON_COUNT:  button_count   <= cfg_data[3:0];
        bcc_pkg::REG_ACTIVE_LEVELS: active_levels  <= cfg_data[7:0];
        bcc_pkg::REG_DEBOUNCED:     cfg.debounced  <= cfg_data[0];
        bcc_pkg::REG_CLICK_TIME:    cfg.click_min  <= cfg_data;
        bcc_pkg::REG_LONG_TIME:     cfg.long_time  <= cfg_data;
        bcc_pkg::REG_DOUBLE_WINDOW: cfg.window     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Number of slots served, clipped to the lane count.
  logic [3:0] limit;
  assign limit = (button_count > 4'(bcc_pkg::BUTTONS)) ? 4'(bcc_pkg::BUTTONS) : button_count;

  // Sequencer.
  bcc_pkg::bcc_state_t state, state_next;
  logic                accept;
  logic                merge_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bcc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = (state != bcc_pkg::ST_IDLE);
    accept     = in_valid && !in_stall;
    unique case (state)
      bcc_pkg::ST_IDLE: begin
        if (accept && (limit != '0)) begin
          state_next = bcc_pkg::ST_LANES;
        end
      end
      bcc_pkg::ST_LANES: begin
        state_next = bcc_pkg::ST_DRAIN;
      end
      bcc_pkg::ST_DRAIN: begin
        if (merge_empty) begin
          state_next = bcc_pkg::ST_IDLE;
        end
      end
      default: state_next = bcc_pkg::ST_IDLE;
    endcase
  end

  // Elapsed time since the previous event, saturated to the hold range.
  logic [31:0]                last_time;
  logic [31:0]                diff;
  logic                       dt_nz;
  logic [bcc_pkg::HOLD_W-1:0] dt_sat;
  logic                       step_nz;
  logic [bcc_pkg::HOLD_W-1:0] step_dt;
  logic [7:0]                 raw_reg;

  assign diff   = in_item.now_ms - last_time;
  assign dt_nz  = (last_time != '0) && (diff != '0);
  assign dt_sat = (diff >= {17'd0, bcc_pkg::HOLD_MAX}) ? bcc_pkg::HOLD_MAX
                                                       : diff[bcc_pkg::HOLD_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      last_time <= '0;
    end else if (accept && (limit != '0)) begin
      last_time <= in_item.now_ms;
    end
  end

  // Hold the item's step data for the lane cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      step_nz <= dt_nz;
      step_dt <= dt_sat;
      raw_reg <= in_item.raw_levels;
    end
  end

  // Lane array: every slot in use updates in the same cycle.
  bcc_pkg::bcc_lane_ev_t [bcc_pkg::BUTTONS-1:0] lane_ev;

  for (genvar g = 0; g < bcc_pkg::BUTTONS; g++) begin : g_lane
    bcc_pkg::bcc_step_t lane_step;
    logic               pressed_now;

    assign lane_step.en    = (state == bcc_pkg::ST_LANES) && (4'(g) < limit);
    assign lane_step.dt_nz = step_nz;
    assign lane_step.dt    = step_dt;
    assign pressed_now     = (raw_reg[g] == active_levels[g]);

    bcc_lane u_lane (
      .clk         (clk),
      .rst         (rst),
      .step        (lane_step),
      .cfg         (cfg),
      .pressed_now (pressed_now),
      .ev          (lane_ev[g])
    );
  end

  // Merge stage: serialize the lane events in slot order.
  bcc_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .load      (state == bcc_pkg::ST_LANES),
    .lane_ev   (lane_ev),
    .empty     (merge_empty),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  `BCC_ASSERT_NEXT(a_accept_to_lanes, accept && (limit != '0),
                   (state == bcc_pkg::ST_LANES) && (last_time == $past(in_item.now_ms)),
                   "accepted item did not reach the lane step")
  `BCC_ASSERT_NEXT(a_no_slots_drop, accept && (limit == '0),
                   (state == bcc_pkg::ST_IDLE) && $stable(last_time),
                   "item with no slots changed state")
  `BCC_ASSERT_NEXT(a_lanes_to_drain, state == bcc_pkg::ST_LANES,
                   state == bcc_pkg::ST_DRAIN, "lane step not followed by drain")

endmodule

`default_nettype wire

@@ tb/tb_button_click_classifier_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the button click classifier top level.
// Depends on bcc_pkg and the design; every event is predicted by a slot model kept here.

module tb_button_click_classifier_top;

  // Worst drain is eight results; leave margin on top.
  localparam int SETTLE_CYCLES = 16;
  localparam int REPORT_LIMIT  = 40;
  // Register indexes past the last register: writes there must change nothing.
  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  bcc_pkg::bcc_in_t  in_item;
  logic              out_valid;
  logic              out_stall;
  bcc_pkg::bcc_out_t out_item;
  logic              cfg_write;
  logic [2:0]        cfg_index;
  logic [14:0]       cfg_data;

  button_click_classifier_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Register copies, as last written through the config port.
  logic [3:0]                 set_count;
  logic [7:0]                 set_levels;
  logic                       set_debounced;
  logic [bcc_pkg::HOLD_W-1:0] set_click;
  logic [bcc_pkg::HOLD_W-1:0] set_long;
  logic [bcc_pkg::HOLD_W-1:0] set_window;

  // Slot state: hold time while held, remaining double-click window once released.
  logic [31:0]                prev_stamp;
  logic                       held      [bcc_pkg::BUTTONS];
  logic                       dbl_armed [bcc_pkg::BUTTONS];
  logic [bcc_pkg::HOLD_W-1:0] slot_ms   [bcc_pkg::BUTTONS];

  bcc_pkg::bcc_out_t expected_events[$];
  int                fail_count;

  // Traffic shaping: calm turns off sender gaps and receiver stalls.
  bit          calm;
  int          burst_left;
  int          stall_run;
  logic [31:0] gen_stamp;
  logic [7:0]  gen_levels;

  task automatic note_mismatch(input string what);
    if (fail_count < REPORT_LIMIT) $display("mismatch at %0t ns: %s", $time, what);
    fail_count++;
  endtask

  task automatic reset_slot_model();
    set_count     = 4'd0;
    set_levels    = 8'h00;
    set_debounced = 1'b0;
    set_click     = 15'd50;
    set_long      = 15'd1000;
    set_window    = 15'd500;
    prev_stamp    = 32'd0;
    for (int i = 0; i < bcc_pkg::BUTTONS; i++) begin
      held[i]      = 1'b0;
      dbl_armed[i] = 1'b0;
      slot_ms[i]   = '0;
    end
  endtask

  // Advance every slot in use by the elapsed time, then classify its new level.
  task automatic classify_edge(input bcc_pkg::bcc_in_t it);
    bcc_pkg::bcc_out_t  batch [bcc_pkg::BUTTONS];
    int                 served;
    int                 found;
    logic [31:0]        dt;
    logic [32:0]        sum;
    logic               is_down;
    bcc_pkg::bcc_kind_t kind;
    served = (set_count > bcc_pkg::BUTTONS) ? bcc_pkg::BUTTONS : int'(set_count);
    if (served == 0) return;
    found = 0;
    dt = (prev_stamp != 32'd0) ? it.now_ms - prev_stamp : 32'd0;
    for (int i = 0; i < served; i++) begin
      if (dt != 32'd0) begin
        if (held[i]) begin
          sum = {1'b0, dt} + 33'(slot_ms[i]);
          slot_ms[i] = (sum >= 33'(bcc_pkg::HOLD_MAX)) ? bcc_pkg::HOLD_MAX
                                                       : sum[bcc_pkg::HOLD_W-1:0];
        end else if (dbl_armed[i]) begin
          if (dt >= 32'(slot_ms[i])) begin
            dbl_armed[i] = 1'b0;
            slot_ms[i]   = '0;
          end else begin
            slot_ms[i] = slot_ms[i] - dt[bcc_pkg::HOLD_W-1:0];
          end
        end
      end
      is_down = (it.raw_levels[i] == set_levels[i]);
      if (is_down) begin
        if (!held[i]) begin
          if (!set_debounced) begin
            batch[found] = '{event_kind: bcc_pkg::KIND_PRESSED, button_index: 3'(i),
                             last_event: 1'b0};
            found++;
          end
          held[i]    = 1'b1;
          slot_ms[i] = '0;
        end
      end else if (held[i]) begin
        if (slot_ms[i] >= set_long) kind = bcc_pkg::KIND_LONG;
        else if (slot_ms[i] >= set_click)
          kind = dbl_armed[i] ? bcc_pkg::KIND_DOUBLE : bcc_pkg::KIND_CLICK;
        else kind = bcc_pkg::KIND_RELEASED;
        if (kind != bcc_pkg::KIND_RELEASED || !set_debounced) begin
          batch[found] = '{event_kind: kind, button_index: 3'(i), last_event: 1'b0};
          found++;
        end
        held[i]      = 1'b0;
        dbl_armed[i] = 1'b1;
        slot_ms[i]   = set_window;
      end
    end
    prev_stamp = it.now_ms;
    if (found > 0) batch[found-1].last_event = 1'b1;
    for (int k = 0; k < found; k++) expected_events.push_back(batch[k]);
  endtask

  // Send one edge item. Open a new burst with a random gap unless calm; keep valid
  // high across back-to-back items so it is never dropped and raised in one step.
  task automatic send_edge(input logic [31:0] stamp, input logic [7:0] levels);
    bcc_pkg::bcc_in_t it;
    int               gap;
    it.now_ms     = stamp;
    it.raw_levels = levels;
    gap = 0;
    if (!calm) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 10);
        gap        = $urandom_range(1, 8);
      end
      burst_left--;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    classify_edge(it);
  endtask

  // Drop valid, drain every expected event, then let a silent item finish too.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Drive the write onto the config port and mirror it into the register copies.
  // The caller drops cfg_write after the last write of a group.
  task automatic write_reg(input logic [2:0] idx, input logic [14:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      bcc_pkg::REG_BUTTON_COUNT:  set_count     = data[3:0];
      bcc_pkg::REG_ACTIVE_LEVELS: set_levels    = data[7:0];
      bcc_pkg::REG_DEBOUNCED:     set_debounced = data[0];
      bcc_pkg::REG_CLICK_TIME:    set_click     = data;
      bcc_pkg::REG_LONG_TIME:     set_long      = data;
      bcc_pkg::REG_DOUBLE_WINDOW: set_window    = data;
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [14:0] count_d, input logic [14:0] levels_d,
                              input logic [14:0] deb_d, input logic [14:0] click_d,
                              input logic [14:0] long_d, input logic [14:0] window_d,
                              input bit with_spares);
    wait_idle();
    write_reg(bcc_pkg::REG_BUTTON_COUNT, count_d);
    write_reg(bcc_pkg::REG_ACTIVE_LEVELS, levels_d);
    write_reg(bcc_pkg::REG_DEBOUNCED, deb_d);
    write_reg(bcc_pkg::REG_CLICK_TIME, click_d);
    write_reg(bcc_pkg::REG_LONG_TIME, long_d);
    write_reg(bcc_pkg::REG_DOUBLE_WINDOW, window_d);
    if (with_spares) begin
      write_reg(REG_SPARE_6, 15'h7FFF);
      write_reg(REG_SPARE_7, 15'h2AAA);
    end
    cfg_write <= 1'b0;
  endtask

  // Out of reset no slot is in use: items vanish and the previous stamp stays zero.
  task automatic test_dropped_when_unused();
    send_edge(32'hDEAD_BEEF, 8'h00);
    send_edge(32'h0000_0001, 8'hFF);
  endtask

  // Reset thresholds (click 50, long 1000, window 500), active-low levels.
  task automatic test_default_thresholds();
    logic [31:0] stamp;
    wait_idle();
    write_reg(bcc_pkg::REG_BUTTON_COUNT, 15'd8);
    cfg_write <= 1'b0;
    stamp = 32'h0000_0100;
    send_edge(stamp, 8'hFF);                 // first event: no elapsed time
    stamp += 16;   send_edge(stamp, 8'hFE);  // press slot 0
    stamp += 20;   send_edge(stamp, 8'hFF);  // short hold: bare release
    stamp += 100;  send_edge(stamp, 8'hFE);  // press inside the double-click window
    stamp += 60;   send_edge(stamp, 8'hFF);  // double click
    stamp += 600;  send_edge(stamp, 8'hFE);  // window has lapsed
    stamp += 70;   send_edge(stamp, 8'hFF);  // plain click
    stamp += 10;   send_edge(stamp, 8'h00);  // all eight slots go down together
    stamp += 2000; send_edge(stamp, 8'hFF);  // long click on every slot
    send_edge(32'hFFFF_FFF0, 8'h7F);         // slot 7 down near the top of the counter
    send_edge(32'h0000_0010, 8'hFF);         // elapsed time wraps through zero
    send_edge(32'h0000_0000, 8'h00);         // a zero stamp is stored as "no event yet"
    send_edge(32'h0000_1388, 8'hFF);         // so this one sees no elapsed time
  endtask

  // Count past the slot limit, debounced, extreme thresholds, spare indexes;
  // then zero thresholds on three slots.
  task automatic test_extreme_thresholds();
    apply_config(15'h000F, 15'h00FF, 15'h0001, 15'h0000, 15'h7FFF, 15'h7FFF, 1'b1);
    send_edge(32'hFFFF_FFFF, 8'hFF);  // every slot down, pressed suppressed
    send_edge(32'h0000_0004, 8'h00);  // tiny hold still beats a zero click time
    send_edge(32'h0000_0010, 8'hFF);  // down again inside the widest window
    send_edge(32'h0001_0010, 8'h0F);  // hold saturates and meets the top long time
    send_edge(32'h0001_0020, 8'h00);  // the rest go up saturated
    apply_config(15'h0003, 15'h0000, 15'h0000, 15'h0000, 15'h0000, 15'h0000, 1'b0);
    send_edge(32'h0001_0021, 8'h00);  // three presses, slots above stay untouched
    send_edge(32'h0001_0022, 8'h07);  // zero long time: every release is long
    send_edge(32'h0001_0022, 8'h00);  // no elapsed time
    send_edge(32'h0001_0030, 8'h05);
  endtask

  // Mostly single-slot toggles with human-like spacing around the thresholds;
  // the rest are multi-slot edges and pure noise, wrapped or zero stamps included.
  task automatic test_random_traffic(input int items, input logic [14:0] count_d,
                                     input logic [14:0] levels_d, input logic [14:0] deb_d,
                                     input logic [14:0] click_d, input logic [14:0] long_d,
                                     input logic [14:0] window_d);
    int          served;
    int          pick;
    logic [31:0] step_ms;
    apply_config(count_d, levels_d, deb_d, click_d, long_d, window_d, 1'b0);
    served = (set_count > bcc_pkg::BUTTONS) ? bcc_pkg::BUTTONS : int'(set_count);
    if (served == 0) served = bcc_pkg::BUTTONS;
    calm = 1'b1;
    for (int n = 0; n < items; n++) begin
      if (n == items / 4) calm = 1'b0;
      pick = $urandom_range(0, 19);
      if (pick < 2) step_ms = 32'd0;
      else if (pick < 8) step_ms = $urandom_range(0, int'(set_click) * 2 + 8);
      else if (pick < 14) step_ms = $urandom_range(0, int'(set_long) + int'(set_window) + 16);
      else if (pick < 17) step_ms = $urandom_range(0, 40000);
      else step_ms = $urandom;
      gen_stamp = gen_stamp + step_ms;
      if (pick == 19) begin
        gen_stamp  = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom);
        gen_levels = 8'($urandom);
      end else if (pick == 18) begin
        gen_levels = gen_levels ^ 8'($urandom);
      end else begin
        pick = $urandom_range(0, served - 1);
        gen_levels[pick] = ~gen_levels[pick];
      end
      send_edge(gen_stamp, gen_levels);
    end
    calm = 1'b0;
  endtask

  // Receiver: stall or run for random stretches; never stall while calm.
  always @(posedge clk) begin
    if (rst || calm) begin
      out_stall <= 1'b0;
      stall_run = 0;
    end else if (stall_run > 0) begin
      stall_run = stall_run - 1;
    end else begin
      stall_run = $urandom_range(0, 11);
      out_stall <= ($urandom_range(0, 99) < 35);
    end
  end

  // Compare each accepted event with the oldest prediction.
  always @(posedge clk) begin
    bcc_pkg::bcc_out_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_events.size() == 0) begin
        note_mismatch($sformatf("unexpected event kind %0d slot %0d last %0b",
                                out_item.event_kind, out_item.button_index,
                                out_item.last_event));
      end else begin
        want = expected_events.pop_front();
        if (out_item.event_kind !== want.event_kind)
          note_mismatch($sformatf("event_kind %0d, expected %0d (slot %0d)",
                                  out_item.event_kind, want.event_kind, want.button_index));
        if (out_item.button_index !== want.button_index)
          note_mismatch($sformatf("button_index %0d, expected %0d",
                                  out_item.button_index, want.button_index));
        if (out_item.last_event !== want.last_event)
          note_mismatch($sformatf("last_event %0b, expected %0b (slot %0d)",
                                  out_item.last_event, want.last_event, want.button_index));
      end
    end
  end

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_item    = '0;
    out_stall  = 1'b0;
    cfg_write  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    calm       = 1'b0;
    burst_left = 0;
    stall_run  = 0;
    fail_count = 0;
    gen_stamp  = 32'h0002_0000;
    gen_levels = 8'hFF;
    reset_slot_model();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_dropped_when_unused();
    test_default_thresholds();
    test_extreme_thresholds();
    test_random_traffic(100, 15'd8, 15'($urandom_range(0, 255)), 15'd0,
                        15'd50, 15'd1000, 15'd500);
    test_random_traffic(70, 15'd5, 15'($urandom_range(0, 255)), 15'd1,
                        15'd20, 15'd300, 15'd200);
    // Slots off: items vanish, state and previous stamp must survive.
    test_random_traffic(12, 15'd0, 15'h00AA, 15'd0, 15'd50, 15'd1000, 15'd500);
    // Junk above each register's width must be ignored.
    test_random_traffic(70, 15'h5A3F, 15'h7F00 | 15'($urandom_range(0, 255)), 15'h7FFE,
                        15'd0, 15'h7FFF, 15'h7FFF);
    test_random_traffic(80, 15'($urandom_range(1, 8)), 15'($urandom_range(0, 255)),
                        15'($urandom_range(0, 1)), 15'($urandom_range(0, 200)),
                        15'($urandom_range(100, 2000)), 15'($urandom_range(0, 1000)));
    test_random_traffic(70, 15'd8, 15'($urandom_range(0, 255)), 15'd0,
                        15'h7FFF, 15'h7FFF, 15'd0);

    wait_idle();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Hang guard: far beyond the slowest correct run.
  initial begin
    #8_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/bcc_pkg.sv
design/bcc_lane.sv
design/bcc_merge.sv
design/button_click_classifier_top.sv
tb/tb_button_click_classifier_top.sv
